// File: rtl/core/region_protection_check_core_macros.svh
// Assertion macros shared by the region protection check checker.
`ifndef REGION_PROTECTION_CHECK_CORE_MACROS_SVH
`define REGION_PROTECTION_CHECK_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rpc_pkg.sv
// Types and constants of the region protection check block.
package rpc_pkg;

  localparam logic [1:0] FN_DEFINE = 2'd0;
  localparam logic [1:0] FN_READ   = 2'd1;
  localparam logic [1:0] FN_WRITE  = 2'd2;
  localparam logic [1:0] FN_FETCH  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NO_PERM   = 2'd2;

  localparam logic [2:0] PERM_R = 3'b001;
  localparam logic [2:0] PERM_W = 3'b010;
  localparam logic [2:0] PERM_X = 3'b100;

  // Width of access sizes after saturation to MAX_ACCESS.
  localparam int ACC_W = 7;

  typedef struct packed {
    logic [63:0] start;
    logic [31:0] length;
    logic [2:0]  rights;
  } region_t;

  typedef struct packed {
    logic        vld;
    logic        hit;
    logic        perm_ok;
    logic [31:0] off;
  } rpc_match_t;

endpackage

// File: rtl/core/rpc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/rpc_match.sv
// Two-stage range and permission compare of one region entry against an access.
module rpc_match #(
  parameter int IDX_W = 3
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      tag_vld,
  input  logic [IDX_W-1:0]          tag_idx,
  input  logic                      tag_ent_vld,
  input  rpc_pkg::region_t          ent,
  input  logic [63:0]               acc_addr,
  input  logic [rpc_pkg::ACC_W-1:0] acc_size,
  input  logic [2:0]                acc_need,
  output rpc_pkg::rpc_match_t       res,
  output logic [IDX_W-1:0]          res_idx
);
  import rpc_pkg::*;

  logic [64:0]      diff_nxt;
  logic             s1_vld_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s1_cand_r;
  logic [31:0]      s1_off_r;
  logic [31:0]      s1_len_r;
  logic             s1_perm_r;
  logic [32:0]      fit_sum;
  logic             fits;
  rpc_match_t       res_r;
  logic [IDX_W-1:0] res_idx_r;

  // A borrow out of the 65-bit difference means the access starts below the region.
  assign diff_nxt = {1'b0, acc_addr} - {1'b0, ent.start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= tag_vld;
    end
    s1_idx_r  <= tag_idx;
    s1_cand_r <= tag_ent_vld && !diff_nxt[64] && (diff_nxt[63:32] == 32'd0);
    s1_off_r  <= diff_nxt[31:0];
    s1_len_r  <= ent.length;
    s1_perm_r <= ((ent.rights & acc_need) == acc_need);
  end

  // The range fits when offset plus size does not pass the region length.
  assign fit_sum = {1'b0, s1_off_r} + 33'(acc_size);
  assign fits    = (fit_sum <= {1'b0, s1_len_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.vld <= 1'b0;
    end else begin
      res_r.vld <= s1_vld_r;
    end
    res_r.hit     <= s1_cand_r && fits;
    res_r.perm_ok <= s1_perm_r;
    res_r.off     <= s1_off_r;
    res_idx_r     <= s1_idx_r;
  end

  assign res     = res_r;
  assign res_idx = res_idx_r;

endmodule

// File: rtl/core/region_protection_check_core.sv
// Top level of the region protection check: sequencer, region table and result register.
//
// The input channel (in_valid / in_stall) takes one item at a time: a define item
// that writes one region slot, or a read, write or fetch access to be checked.
// The result channel (out_valid / out_stall) returns exactly one item for each
// input item, in order.
// A define item writes its slot in S_DEF, and its result is loaded in S_FIN. An
// access reads the region table one entry per cycle from the single read port of the
// table memory, then each entry passes a two-stage compare, and its result is loaded
// in S_FIN; all REGIONS entries are always scanned and the lowest matching slot is
// kept. The next item can be accepted in the cycle after the result is loaded, even
// if the previous result is still waiting to be taken.
// Reset clears the valid marks of all regions, so the table reads as empty; the
// table memory itself is not cleared and needs no clearing pass.
// While the receiver stalls, the result holds and at most one more item is
// worked off before the block stops taking input.
module region_protection_check_core #(
  parameter int REGIONS    = 8,
  parameter int MAX_ACCESS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [2:0]  in_slot,
  input  logic [63:0] in_address,
  input  logic [31:0] in_length,
  input  logic [2:0]  in_region_perm,
  input  logic [4:0]  in_access_size,
  input  logic [2:0]  in_extra_perm,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_region_index,
  output logic [31:0] out_offset
);
  import rpc_pkg::*;

  localparam int IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int CNT_W = $clog2(REGIONS + 1);
  localparam int ENT_W = $bits(region_t);
  localparam logic [ACC_W-1:0] MAX_SZ = ACC_W'(MAX_ACCESS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEF  = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t             state_r;
  logic [1:0]         func_r;
  logic [2:0]         slot_r;
  logic [63:0]        addr_r;
  logic [31:0]        len_r;
  logic [2:0]         perm_r;
  logic [ACC_W-1:0]   size_r;
  logic [2:0]         need_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [REGIONS-1:0] valid_r;
  logic               iss_vld_r;
  logic [IDX_W-1:0]   iss_idx_r;
  logic               iss_ev_r;
  logic               found_r;
  logic               hit_perm_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [31:0]        hit_off_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [2:0]         out_index_r;
  logic [31:0]        out_offset_r;

  logic [ACC_W-1:0]   size_ext;
  logic [ACC_W-1:0]   size_nxt;
  logic [2:0]         need_nxt;
  logic               in_acc;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  region_t            wr_ent;
  logic [ENT_W-1:0]   rd_data;
  rpc_match_t         res;
  logic [IDX_W-1:0]   res_idx;
  logic               res_last;
  logic               out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign size_ext = ACC_W'(in_access_size);
  assign size_nxt = (size_ext > MAX_SZ) ? MAX_SZ : size_ext;

  always_comb begin
    unique case (in_func)
      FN_READ:  need_nxt = in_extra_perm | PERM_R;
      FN_WRITE: need_nxt = in_extra_perm | PERM_W;
      FN_FETCH: need_nxt = PERM_X;
      default:  need_nxt = 3'b000;
    endcase
  end

  // Table write for define items; a zero length clears the slot.
  assign wr_en   = (state_r == S_DEF) && (int'(slot_r) < REGIONS);
  assign wr_addr = IDX_W'(slot_r);
  always_comb begin
    if (len_r == 32'd0) begin
      wr_ent = '0;
    end else begin
      wr_ent.start  = addr_r;
      wr_ent.length = len_r;
      wr_ent.rights = perm_r;
    end
  end

  assign rd_en    = (state_r == S_SCAN) && (cnt_r < CNT_W'(REGIONS));
  assign rd_addr  = cnt_r[IDX_W-1:0];
  assign res_last = res.vld && (res_idx == IDX_W'(REGIONS - 1));

  rpc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (REGIONS)
  ) u_rpc_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_ent),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rpc_match #(
    .IDX_W (IDX_W)
  ) u_rpc_match (
    .clk         (clk),
    .rst_n       (rst_n),
    .tag_vld     (iss_vld_r),
    .tag_idx     (iss_idx_r),
    .tag_ent_vld (iss_ev_r),
    .ent         (region_t'(rd_data)),
    .acc_addr    (addr_r),
    .acc_size    (size_r),
    .acc_need    (need_r),
    .res         (res),
    .res_idx     (res_idx)
  );

  // Item capture and read tags that travel alongside the table read.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      slot_r <= in_slot;
      addr_r <= in_address;
      len_r  <= in_length;
      perm_r <= in_region_perm;
      size_r <= size_nxt;
      need_r <= need_nxt;
    end
    iss_idx_r <= rd_addr;
    iss_ev_r  <= valid_r[rd_addr];
    if (res.vld && res.hit && !found_r) begin
      hit_perm_r <= res.perm_ok;
      hit_idx_r  <= res_idx;
      hit_off_r  <= res.off;
    end
    if (state_r == S_FIN && out_free) begin
      if (func_r == FN_DEFINE) begin
        out_status_r <= ST_OK;
        out_index_r  <= 3'd0;
        out_offset_r <= 32'd0;
      end else if (found_r) begin
        out_status_r <= hit_perm_r ? ST_OK : ST_NO_PERM;
        out_index_r  <= 3'(hit_idx_r);
        out_offset_r <= hit_off_r;
      end else begin
        out_status_r <= ST_NOT_FOUND;
        out_index_r  <= 3'd0;
        out_offset_r <= 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      valid_r     <= '0;
      iss_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      iss_vld_r <= rd_en;
      if (wr_en) begin
        valid_r[wr_addr] <= (len_r != 32'd0);
      end
      if (rd_en) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (res.vld && res.hit) begin
        found_r <= 1'b1;
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cnt_r   <= '0;
            found_r <= 1'b0;
            state_r <= (in_func == FN_DEFINE) ? S_DEF : S_SCAN;
          end
        end
        S_DEF: begin
          state_r <= S_FIN;
        end
        S_SCAN: begin
          if (res_last) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_region_index = out_index_r;
  assign out_offset       = out_offset_r;

endmodule

// File: rtl/core/rpc_checker.sv
// Port-level assertions for the region protection check, bound to the top level.
`include "region_protection_check_core_macros.svh"

module rpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [2:0]  out_region_index,
  input logic [31:0] out_offset
);
  import rpc_pkg::*;

  `RPC_ASSERT_NOW(a_status_code, clk, rst_n, out_valid,
    (out_status == ST_OK) || (out_status == ST_NOT_FOUND) || (out_status == ST_NO_PERM),
    "result status is not a defined code")

  `RPC_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && (out_status == ST_NOT_FOUND),
    (out_region_index == 3'd0) && (out_offset == 32'd0),
    "a miss must report slot zero and offset zero")

  // Only one item is worked on at a time.
  `RPC_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall,
    "input accepted on two consecutive cycles")

  `RPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_status) && $stable(out_region_index) && $stable(out_offset),
    "stalled result changed")

endmodule

bind region_protection_check_core rpc_checker u_rpc_checker (.*);
